/* rtl/core/cwct_pkg.sv */
// shared constants, types and helper functions of the color window centroid tracker
package cwct_pkg;

   localparam int COORD_BITS     = 12;
   localparam int MAX_WINDOW     = 512;
   localparam int CFG_BITS       = 24;
   localparam int SIZE_BITS      = 10;
   localparam int POS_BITS       = COORD_BITS + 1;
   localparam int EXT_BITS       = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
   localparam int COUNT_BITS     = 19;
   localparam int SUM_BITS       = 31;
   localparam int CHAN_BITS      = 8;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWER_BOUND    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UPPER_BOUND    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIN_WIDTH      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIN_HEIGHT     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_POSITION = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_LIMITS       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_LIMITS       = 3'd6;

   typedef struct packed {
      logic [CFG_BITS-1:0]  lower_bound;
      logic [CFG_BITS-1:0]  upper_bound;
      logic [SIZE_BITS-1:0] win_width;
      logic [SIZE_BITS-1:0] win_height;
      logic [CFG_BITS-1:0]  start_position;
      logic [CFG_BITS-1:0]  x_limits;
      logic [CFG_BITS-1:0]  y_limits;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      lower_bound:    24'd0,
      upper_bound:    24'd16777215,
      win_width:      10'd50,
      win_height:     10'd50,
      start_position: 24'd819300,
      x_limits:       24'd2621440,
      y_limits:       24'd1966080
   };

   // new window handed from the back end to the front end
   typedef struct packed {
      logic                       valid;
      logic signed [POS_BITS-1:0] win_x;
      logic signed [POS_BITS-1:0] win_y;
   } win_upd_type;

   // classified pixel in the queue
   typedef struct packed {
      logic                  init;
      logic [COORD_BITS-1:0] cinit_x;
      logic [COORD_BITS-1:0] cinit_y;
      logic                  match;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  frame_end;
   } entry_type;

   // window size clamped to 1..MAX_WINDOW
   function automatic logic [SIZE_BITS-1:0] win_size(input logic [SIZE_BITS-1:0] v);
      logic [SIZE_BITS-1:0] r;
      if (v == '0) begin
         r = SIZE_BITS'(1);
      end else if (32'(v) > MAX_WINDOW) begin
         r = SIZE_BITS'(MAX_WINDOW);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [COORD_BITS-1:0] lo_coord(input logic [CFG_BITS-1:0] v);
      return v[COORD_BITS-1:0];
   endfunction

   function automatic logic [COORD_BITS-1:0] hi_coord(input logic [CFG_BITS-1:0] v);
      return COORD_BITS'(v >> COORD_BITS);
   endfunction

endpackage

/* rtl/core/cwct_if.sv */
// request and result stream interfaces of the tracker
interface cwct_req_if import cwct_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAN_BITS-1:0]  pixel_blue;
   logic [CHAN_BITS-1:0]  pixel_green;
   logic [CHAN_BITS-1:0]  pixel_red;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  frame_end;

   modport source (
      output valid, pixel_blue, pixel_green, pixel_red, pixel_x, pixel_y, frame_end,
      input  ready
   );
   modport sink (
      input  valid, pixel_blue, pixel_green, pixel_red, pixel_x, pixel_y, frame_end,
      output ready
   );
endinterface

interface cwct_rsp_if import cwct_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [POS_BITS-1:0] new_window_x;
   logic signed [POS_BITS-1:0] new_window_y;
   logic [COORD_BITS-1:0]      center_x;
   logic [COORD_BITS-1:0]      center_y;
   logic                       found;

   modport source (
      output valid, new_window_x, new_window_y, center_x, center_y, found,
      input  ready
   );
   modport sink (
      input  valid, new_window_x, new_window_y, center_x, center_y, found,
      output ready
   );
endinterface

/* rtl/core/color_window_centroid_tracker.sv */
// top level of the color window centroid tracker
//
// Pixel requests of a raster frame are taken one per clock while the request port is ready.
// A pixel counts when blue, green and red each lie within lower_bound..upper_bound and it
// falls inside the tracking window; counted pixels add to a match count and to column and row
// sums. The request marked frame_end closes the frame: the back end divides the sums by the
// count in a shared restoring divider (one quotient bit per cycle), keeps the old centroid
// when nothing matched, recenters the window on the centroid, clamps it left then right and
// top then bottom, and posts one result. The next frame's window depends on that result, so
// after a frame_end request the request port stays not ready until the new window is back,
// including any time the result register waits for a previous result to be taken.
// The first pixel after reset loads the window from start_position; later writes of
// start_position have no effect until reset. Window sizes outside 1..512 are clamped.
// No clearing pass is needed after reset.
module color_window_centroid_tracker import cwct_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   cwct_req_if.sink                  req_if,
   cwct_rsp_if.source                rsp_if,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_write_data
);

   // configuration registers
   cfg_type     cfg_ff;

   // front to queue and queue to back
   logic        fq_valid, fq_ready;
   entry_type   fq_data;
   logic        qb_valid, qb_ready;
   entry_type   qb_data;

   // new window back to the front end
   win_upd_type upd_s;

   // csr writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LOWER_BOUND:    cfg_ff.lower_bound    <= csr_write_data;
            CSR_UPPER_BOUND:    cfg_ff.upper_bound    <= csr_write_data;
            CSR_WIN_WIDTH:      cfg_ff.win_width      <= csr_write_data[SIZE_BITS-1:0];
            CSR_WIN_HEIGHT:     cfg_ff.win_height     <= csr_write_data[SIZE_BITS-1:0];
            CSR_START_POSITION: cfg_ff.start_position <= csr_write_data;
            CSR_X_LIMITS:       cfg_ff.x_limits       <= csr_write_data;
            CSR_Y_LIMITS:       cfg_ff.y_limits       <= csr_write_data;
            default: ;
         endcase
      end
   end

   // classify each request against color bounds and window
   cwct_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .cfg     (cfg_ff),
      .upd     (upd_s),
      .q_valid (fq_valid),
      .q_ready (fq_ready),
      .q_data  (fq_data)
   );

   // short queue so front and back stall on their own
   cwct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   // accumulate, divide, place and emit
   cwct_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (qb_valid),
      .q_ready (qb_ready),
      .q_data  (qb_data),
      .upd     (upd_s),
      .rsp_if  (rsp_if)
   );

   // a frame_end request blocks the next request until the new window is back
   a_hold_after_frame_end: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && req_if.frame_end |=> !req_if.ready)
      else $error("request accepted right after frame end");

   // window update never lands in the same cycle as an accepted request
   a_no_accept_on_update: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |-> !upd_s.valid)
      else $error("request accepted while window update pending");

   // window update goes out together with a posted result
   a_update_with_result: assert property (@(posedge clock) disable iff (reset)
      upd_s.valid |-> rsp_if.valid)
      else $error("window update without result");

endmodule

/* rtl/core/cwct_queue.sv */
// two-entry queue of classified pixels between front and back end
module cwct_queue import cwct_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_data
);

   entry_type  entries_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* rtl/core/cwct_divider.sv */
// restoring divider, two dividends over one divisor, one quotient bit per cycle
module cwct_divider import cwct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SUM_BITS-1:0]   dividend_x,
   input  logic [SUM_BITS-1:0]   dividend_y,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output logic [COORD_BITS-1:0] quot_x,
   output logic [COORD_BITS-1:0] quot_y
);

   localparam int STEP_BITS = $clog2(SUM_BITS);

   logic                  run_ff;
   logic                  done_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [COUNT_BITS:0]   rem_x_ff, rem_y_ff;
   logic [SUM_BITS-1:0]   shf_x_ff, shf_y_ff;
   logic [COUNT_BITS-1:0] div_ff;
   logic [COUNT_BITS:0]   try_x, try_y, rem_x_in, rem_y_in;
   logic [SUM_BITS-1:0]   shf_x_in, shf_y_in;
   logic                  ge_x, ge_y;

   always_comb begin
      try_x    = {rem_x_ff[COUNT_BITS-1:0], shf_x_ff[SUM_BITS-1]};
      try_y    = {rem_y_ff[COUNT_BITS-1:0], shf_y_ff[SUM_BITS-1]};
      ge_x     = (try_x >= {1'b0, div_ff});
      ge_y     = (try_y >= {1'b0, div_ff});
      rem_x_in = ge_x ? (try_x - {1'b0, div_ff}) : try_x;
      rem_y_in = ge_y ? (try_y - {1'b0, div_ff}) : try_y;
      // quotient bits shift in as dividend bits shift out
      shf_x_in = {shf_x_ff[SUM_BITS-2:0], ge_x};
      shf_y_in = {shf_y_ff[SUM_BITS-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shf_x_ff <= dividend_x;
         shf_y_ff <= dividend_y;
         rem_x_ff <= '0;
         rem_y_ff <= '0;
         div_ff   <= divisor;
      end else if (run_ff) begin
         shf_x_ff <= shf_x_in;
         shf_y_ff <= shf_y_in;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
      end
   end

   assign done   = done_ff;
   assign quot_x = shf_x_ff[COORD_BITS-1:0];
   assign quot_y = shf_y_ff[COORD_BITS-1:0];

endmodule

/* rtl/core/cwct_front.sv */
// front end: accepts pixel requests, tests color and window, feeds the queue
module cwct_front import cwct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cwct_req_if.sink    req_if,
   input  cfg_type     cfg,
   input  win_upd_type upd,
   output logic        q_valid,
   input  logic        q_ready,
   output entry_type   q_data
);

   logic                       first_ff;
   logic                       hold_ff;
   logic signed [POS_BITS-1:0] wx_ff, wy_ff;
   logic [SIZE_BITS-1:0]       w_size, h_size;
   logic [COORD_BITS-1:0]      start_x, start_y;
   logic signed [POS_BITS-1:0] cur_wx, cur_wy;
   logic signed [EXT_BITS-1:0] px_ext, py_ext, left, right, top, bottom;
   logic [POS_BITS-1:0]        mid_x, mid_y;
   logic                       color_ok, in_window, accept;

   function automatic logic chan_ok(input logic [CHAN_BITS-1:0] v,
                                    input logic [CHAN_BITS-1:0] lo,
                                    input logic [CHAN_BITS-1:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   always_comb begin
      w_size  = win_size(cfg.win_width);
      h_size  = win_size(cfg.win_height);
      start_x = lo_coord(cfg.start_position);
      start_y = hi_coord(cfg.start_position);
      // window comes from the start position on the very first pixel
      cur_wx  = first_ff ? $signed(POS_BITS'(start_x)) : wx_ff;
      cur_wy  = first_ff ? $signed(POS_BITS'(start_y)) : wy_ff;
      left    = EXT_BITS'(cur_wx);
      top     = EXT_BITS'(cur_wy);
      right   = left + $signed(EXT_BITS'(w_size));
      bottom  = top + $signed(EXT_BITS'(h_size));
      px_ext  = $signed(EXT_BITS'(req_if.pixel_x));
      py_ext  = $signed(EXT_BITS'(req_if.pixel_y));
      color_ok = chan_ok(req_if.pixel_blue, cfg.lower_bound[7:0], cfg.upper_bound[7:0])
              && chan_ok(req_if.pixel_green, cfg.lower_bound[15:8], cfg.upper_bound[15:8])
              && chan_ok(req_if.pixel_red, cfg.lower_bound[23:16], cfg.upper_bound[23:16]);
      in_window = (px_ext >= left) && (px_ext < right) && (py_ext >= top) && (py_ext < bottom);
      // initial centroid, saturated at the largest coordinate
      mid_x = POS_BITS'(start_x) + POS_BITS'(w_size >> 1);
      mid_y = POS_BITS'(start_y) + POS_BITS'(h_size >> 1);
   end

   assign req_if.ready = !hold_ff && q_ready;
   assign q_valid      = req_if.valid && !hold_ff;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      q_data.init      = first_ff;
      q_data.cinit_x   = mid_x[POS_BITS-1] ? '1 : mid_x[COORD_BITS-1:0];
      q_data.cinit_y   = mid_y[POS_BITS-1] ? '1 : mid_y[COORD_BITS-1:0];
      q_data.match     = color_ok && in_window;
      q_data.pixel_x   = req_if.pixel_x;
      q_data.pixel_y   = req_if.pixel_y;
      q_data.frame_end = req_if.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         hold_ff  <= 1'b0;
         wx_ff    <= '0;
         wy_ff    <= '0;
      end else begin
         if (accept) begin
            if (first_ff) begin
               wx_ff    <= cur_wx;
               wy_ff    <= cur_wy;
               first_ff <= 1'b0;
            end
            // no more pixels until the back end returns the new window
            if (req_if.frame_end) begin
               hold_ff <= 1'b1;
            end
         end
         if (upd.valid) begin
            wx_ff   <= upd.win_x;
            wy_ff   <= upd.win_y;
            hold_ff <= 1'b0;
         end
      end
   end

endmodule

/* rtl/core/cwct_back.sv */
// back end: accumulates matches, divides at frame end, places the window, emits results
module cwct_back import cwct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   output logic        q_ready,
   input  entry_type   q_data,
   output win_upd_type upd,
   cwct_rsp_if.source  rsp_if
);

   localparam logic [2:0] ST_ACCUM    = 3'd0;
   localparam logic [2:0] ST_DIVIDE   = 3'd1;
   localparam logic [2:0] ST_PLACE_LO = 3'd2;
   localparam logic [2:0] ST_PLACE_HI = 3'd3;
   localparam logic [2:0] ST_EMIT     = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic [SUM_BITS-1:0]        sum_x_ff, sum_y_ff, sum_x_in, sum_y_in;
   logic [COORD_BITS-1:0]      cent_x_ff, cent_y_ff;
   logic                       found_ff;
   logic signed [EXT_BITS-1:0] pos_x_ff, pos_y_ff;
   logic                       rsp_valid_ff;
   logic                       upd_valid_ff;
   logic signed [POS_BITS-1:0] out_wx_ff, out_wy_ff;
   logic [COORD_BITS-1:0]      out_cx_ff, out_cy_ff;
   logic                       out_found_ff;

   logic                       pop, hit, div_start, div_done, emit;
   logic [COORD_BITS-1:0]      quot_x, quot_y;
   logic [SIZE_BITS-1:0]       w_size, h_size;
   logic signed [EXT_BITS-1:0] w_ext, h_ext, lo_x, lo_y, hi_x, hi_y;
   logic signed [EXT_BITS-1:0] cand_x, cand_y, place_lo_x, place_lo_y;
   logic signed [EXT_BITS-1:0] place_hi_x, place_hi_y;

   assign q_ready = (state_ff == ST_ACCUM);
   assign pop     = q_valid && q_ready;

   always_comb begin
      hit       = q_data.match && (count_ff != COUNT_MAX);
      count_in  = count_ff + COUNT_BITS'(hit);
      sum_x_in  = sum_x_ff + (hit ? SUM_BITS'(q_data.pixel_x) : '0);
      sum_y_in  = sum_y_ff + (hit ? SUM_BITS'(q_data.pixel_y) : '0);
      div_start = pop && q_data.frame_end && (count_in != '0);
      emit      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_if.ready);
   end

   cwct_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_x (sum_x_in),
      .dividend_y (sum_y_in),
      .divisor    (count_in),
      .done       (div_done),
      .quot_x     (quot_x),
      .quot_y     (quot_y)
   );

   // window placement: recenter and clamp left or top, then right or bottom
   always_comb begin
      w_size     = win_size(cfg.win_width);
      h_size     = win_size(cfg.win_height);
      w_ext      = $signed(EXT_BITS'(w_size));
      h_ext      = $signed(EXT_BITS'(h_size));
      lo_x       = $signed(EXT_BITS'(lo_coord(cfg.x_limits)));
      hi_x       = $signed(EXT_BITS'(hi_coord(cfg.x_limits)));
      lo_y       = $signed(EXT_BITS'(lo_coord(cfg.y_limits)));
      hi_y       = $signed(EXT_BITS'(hi_coord(cfg.y_limits)));
      cand_x     = $signed(EXT_BITS'(cent_x_ff)) - $signed(EXT_BITS'(w_size >> 1));
      cand_y     = $signed(EXT_BITS'(cent_y_ff)) - $signed(EXT_BITS'(h_size >> 1));
      place_lo_x = (cand_x < lo_x) ? lo_x : cand_x;
      place_lo_y = (cand_y < lo_y) ? lo_y : cand_y;
      place_hi_x = ((pos_x_ff + w_ext) > hi_x) ? (hi_x - w_ext) : pos_x_ff;
      place_hi_y = ((pos_y_ff + h_ext) > hi_y) ? (hi_y - h_ext) : pos_y_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (pop && q_data.frame_end) begin
               state_in = (count_in != '0) ? ST_DIVIDE : ST_PLACE_LO;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_PLACE_LO;
            end
         end
         ST_PLACE_LO: state_in = ST_PLACE_HI;
         ST_PLACE_HI: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit) begin
               state_in = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         count_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         cent_x_ff    <= '0;
         cent_y_ff    <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         upd_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upd_valid_ff <= emit;
         if (pop) begin
            if (q_data.init) begin
               cent_x_ff <= q_data.cinit_x;
               cent_y_ff <= q_data.cinit_y;
            end
            if (q_data.frame_end) begin
               found_ff <= (count_in != '0);
               count_ff <= '0;
               sum_x_ff <= '0;
               sum_y_ff <= '0;
            end else begin
               count_ff <= count_in;
               sum_x_ff <= sum_x_in;
               sum_y_ff <= sum_y_in;
            end
         end
         if ((state_ff == ST_DIVIDE) && div_done) begin
            cent_x_ff <= quot_x;
            cent_y_ff <= quot_y;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PLACE_LO) begin
         pos_x_ff <= place_lo_x;
         pos_y_ff <= place_lo_y;
      end else if (state_ff == ST_PLACE_HI) begin
         pos_x_ff <= place_hi_x;
         pos_y_ff <= place_hi_y;
      end
      if (emit) begin
         out_wx_ff    <= POS_BITS'(pos_x_ff);
         out_wy_ff    <= POS_BITS'(pos_y_ff);
         out_cx_ff    <= cent_x_ff;
         out_cy_ff    <= cent_y_ff;
         out_found_ff <= found_ff;
      end
   end

   assign upd.valid           = upd_valid_ff;
   assign upd.win_x           = out_wx_ff;
   assign upd.win_y           = out_wy_ff;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.new_window_x = out_wx_ff;
   assign rsp_if.new_window_y = out_wy_ff;
   assign rsp_if.center_x     = out_cx_ff;
   assign rsp_if.center_y     = out_cy_ff;
   assign rsp_if.found        = out_found_ff;

endmodule

/* bench/color_window_centroid_tracker_test.sv */
// self-checking testbench of the color window centroid tracker
module color_window_centroid_tracker_test;
   import cwct_pkg::*;

   // quiet cycles after the last result before the block counts as idle
   localparam int SETTLE_CYCLES = 64;
   // idling mix of the random phases: no idling, sender idle, receiver stall, both
   localparam int SEND_IDLE[4] = '{0, 48, 0, 14};
   localparam int RECV_STALL[4] = '{0, 0, 48, 14};
   localparam int PHASE_ITEMS = 94;

   // one pixel request as the sender sees it
   typedef struct {
      logic [CHAN_BITS-1:0]  blue;
      logic [CHAN_BITS-1:0]  green;
      logic [CHAN_BITS-1:0]  red;
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic                  frame_end;
   } pixel_type;

   // one tracking result per closed frame
   typedef struct {
      logic signed [POS_BITS-1:0] new_window_x;
      logic signed [POS_BITS-1:0] new_window_y;
      logic [COORD_BITS-1:0]      center_x;
      logic [COORD_BITS-1:0]      center_y;
      logic                       found;
   } track_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]       csr_write_data;

   cwct_req_if req_bus ();
   cwct_rsp_if rsp_bus ();

   color_window_centroid_tracker dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // tracker state as predicted from accepted requests
   cfg_type     setup = CFG_RESET;
   int          trk_win_x;
   int          trk_win_y;
   int          trk_cen_x;
   int          trk_cen_y;
   bit          trk_first;
   int          trk_count;
   int unsigned trk_sum_x;
   int unsigned trk_sum_y;

   // results predicted but not yet seen on the result port
   track_type pending_tracks[$];

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // generous ceiling on the whole run, a correct run needs well under 100k time units
   initial begin
      #1_000_000;
      $display("FAIL color_window_centroid_tracker");
      $finish;
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------------------

   // window size register clamped to 1..MAX_WINDOW
   function automatic int window_span(input logic [SIZE_BITS-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > MAX_WINDOW) begin
         return MAX_WINDOW;
      end
      return int'(v);
   endfunction

   // saturate to the coordinate range
   function automatic int sat_coord(input int v);
      if (v < 0) begin
         return 0;
      end
      if (v > (1 << COORD_BITS) - 1) begin
         return (1 << COORD_BITS) - 1;
      end
      return v;
   endfunction

   // center a window of the given span on c, then clamp low edge first, high edge last
   function automatic int recenter(input int c, input int span, input int lo_lim, input int hi_lim);
      int p;
      p = c - span / 2;
      if (p < lo_lim) begin
         p = lo_lim;
      end
      if (p + span > hi_lim) begin
         p = hi_lim - span;
      end
      return p;
   endfunction

   // channel k (0 blue, 1 green, 2 red) inside its inclusive bounds
   function automatic bit channel_ok(input logic [CHAN_BITS-1:0] v, input int k);
      return v >= setup.lower_bound[8*k +: 8] && v <= setup.upper_bound[8*k +: 8];
   endfunction

   // advance the predicted tracker by one accepted pixel request
   task automatic track_pixel(input pixel_type px);
      int        w;
      int        h;
      bit        hit;
      track_type res;
      w = window_span(setup.win_width);
      h = window_span(setup.win_height);
      // very first pixel after reset seeds the window and a provisional centroid
      if (trk_first) begin
         trk_win_x = int'(setup.start_position[COORD_BITS-1:0]);
         trk_win_y = int'(setup.start_position[2*COORD_BITS-1:COORD_BITS]);
         trk_cen_x = sat_coord(trk_win_x + w / 2);
         trk_cen_y = sat_coord(trk_win_y + h / 2);
         trk_first = 1'b0;
      end
      hit = channel_ok(px.blue, 0) && channel_ok(px.green, 1) && channel_ok(px.red, 2) &&
            int'(px.col) >= trk_win_x && int'(px.col) < trk_win_x + w &&
            int'(px.row) >= trk_win_y && int'(px.row) < trk_win_y + h &&
            trk_count < int'(COUNT_MAX);
      if (hit) begin
         trk_count++;
         trk_sum_x += 32'(px.col);
         trk_sum_y += 32'(px.row);
      end
      if (px.frame_end) begin
         // empty frame keeps the old centroid
         res.found = (trk_count != 0);
         if (res.found) begin
            trk_cen_x = int'((trk_sum_x / trk_count) & 32'hFFF);
            trk_cen_y = int'((trk_sum_y / trk_count) & 32'hFFF);
         end
         trk_win_x = recenter(trk_cen_x, w, int'(setup.x_limits[COORD_BITS-1:0]),
                              int'(setup.x_limits[2*COORD_BITS-1:COORD_BITS]));
         trk_win_y = recenter(trk_cen_y, h, int'(setup.y_limits[COORD_BITS-1:0]),
                              int'(setup.y_limits[2*COORD_BITS-1:COORD_BITS]));
         res.new_window_x = POS_BITS'(trk_win_x);
         res.new_window_y = POS_BITS'(trk_win_y);
         res.center_x = COORD_BITS'(trk_cen_x);
         res.center_y = COORD_BITS'(trk_cen_y);
         pending_tracks.push_back(res);
         trk_count = 0;
         trk_sum_x = 0;
         trk_sum_y = 0;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // every accepted result is matched against the oldest prediction
   always @(posedge clock) begin : check_results
      track_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_tracks.size() == 0) begin
            $error("unexpected result: window %0d,%0d center %0d,%0d",
                   rsp_bus.new_window_x, rsp_bus.new_window_y,
                   rsp_bus.center_x, rsp_bus.center_y);
            error_count++;
         end else begin
            want = pending_tracks.pop_front();
            compare_field("new_window_x", 32'(want.new_window_x), 32'(rsp_bus.new_window_x));
            compare_field("new_window_y", 32'(want.new_window_y), 32'(rsp_bus.new_window_y));
            compare_field("center_x", 32'(want.center_x), 32'(rsp_bus.center_x));
            compare_field("center_y", 32'(want.center_y), 32'(rsp_bus.center_y));
            compare_field("found", 32'(want.found), 32'(rsp_bus.found));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------

   // rgb packed like the bound registers: blue 7:0, green 15:8, red 23:16
   function automatic pixel_type make_pixel(input logic [23:0] rgb, input int col, input int row,
                                            input bit frame_end);
      pixel_type px;
      px.blue = rgb[7:0];
      px.green = rgb[15:8];
      px.red = rgb[23:16];
      px.col = COORD_BITS'(sat_coord(col));
      px.row = COORD_BITS'(sat_coord(row));
      px.frame_end = frame_end;
      return px;
   endfunction

   // pixel placed relative to the predicted window's top left corner
   function automatic pixel_type near_window(input int dx, input int dy, input logic [23:0] rgb,
                                             input bit frame_end);
      return make_pixel(rgb, trk_win_x + dx, trk_win_y + dy, frame_end);
   endfunction

   // pixel of a well-formed frame: mostly in bounds and in or around the window
   function automatic pixel_type frame_pixel(input bit frame_end);
      int          w;
      int          h;
      int          k;
      logic [23:0] rgb;
      logic [7:0]  lo;
      logic [7:0]  hi;
      w = window_span(setup.win_width);
      h = window_span(setup.win_height);
      for (k = 0; k < 3; k++) begin
         lo = setup.lower_bound[8*k +: 8];
         hi = setup.upper_bound[8*k +: 8];
         if (lo <= hi && $urandom_range(9) != 0) begin
            rgb[8*k +: 8] = 8'($urandom_range(hi, lo));
         end else begin
            rgb[8*k +: 8] = 8'($urandom_range(255));
         end
      end
      return near_window(int'($urandom_range(w + 15)) - 8, int'($urandom_range(h + 15)) - 8,
                         rgb, frame_end);
   endfunction

   // send one pixel request, with random sender gaps; returns at the accepting edge
   task automatic send_pixel(input pixel_type px);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.pixel_blue = px.blue;
      req_bus.pixel_green = px.green;
      req_bus.pixel_red = px.red;
      req_bus.pixel_x = px.col;
      req_bus.pixel_y = px.row;
      req_bus.frame_end = px.frame_end;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      track_pixel(px);
   endtask

   // stop requesting and wait for every predicted result
   task automatic hold_until_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_tracks.size() != 0) @(posedge clock);
   endtask

   // drained plus time for pixels still in flight inside the block
   task automatic wait_until_idle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      req_bus.valid = 1'b0;
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_LOWER_BOUND:    setup.lower_bound = value;
         CSR_UPPER_BOUND:    setup.upper_bound = value;
         CSR_WIN_WIDTH:      setup.win_width = value[SIZE_BITS-1:0];
         CSR_WIN_HEIGHT:     setup.win_height = value[SIZE_BITS-1:0];
         CSR_START_POSITION: setup.start_position = value;
         CSR_X_LIMITS:       setup.x_limits = value;
         CSR_Y_LIMITS:       setup.y_limits = value;
         default: ;
      endcase
   endtask

   // limit pair: mostly an ordered range, sometimes any 24 bits (crossed limits included)
   function automatic logic [CFG_BITS-1:0] random_limits();
      int lo;
      if ($urandom_range(5) == 0) begin
         return CFG_BITS'($urandom);
      end
      lo = $urandom_range(1500);
      return {COORD_BITS'(lo + int'($urandom_range(2595))), COORD_BITS'(lo)};
   endfunction

   function automatic logic [SIZE_BITS-1:0] random_size();
      if ($urandom_range(5) == 0) begin
         return SIZE_BITS'($urandom_range(1023));
      end
      return SIZE_BITS'($urandom_range(96, 1));
   endfunction

   // fresh configuration for a random phase
   task automatic pick_random_setup();
      logic [23:0] lo;
      logic [23:0] hi;
      int          k;
      if ($urandom_range(5) == 0) begin
         lo = 24'($urandom);
         hi = 24'($urandom);
      end else begin
         for (k = 0; k < 3; k++) begin
            lo[8*k +: 8] = 8'($urandom_range(90));
            hi[8*k +: 8] = 8'($urandom_range(255, 140));
         end
      end
      write_register(CSR_LOWER_BOUND, lo);
      write_register(CSR_UPPER_BOUND, hi);
      write_register(CSR_WIN_WIDTH, CFG_BITS'(random_size()));
      write_register(CSR_WIN_HEIGHT, CFG_BITS'(random_size()));
      // no effect after the first pixel, still a legal write
      write_register(CSR_START_POSITION, CFG_BITS'($urandom));
      write_register(CSR_X_LIMITS, random_limits());
      write_register(CSR_Y_LIMITS, random_limits());
   endtask

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // first frame after reset: window seeded from start_position, centroid saturates,
   // oversized width and zero height are clamped, nothing matches so the seed is kept
   task automatic test_initial_window();
      write_register(CSR_START_POSITION, {12'd4080, 12'd4000});
      write_register(CSR_WIN_WIDTH, 24'd1023);
      write_register(CSR_WIN_HEIGHT, 24'd0);
      send_pixel(make_pixel(24'h000000, 4095, 4095, 1'b0));
      send_pixel(make_pixel(24'hFFFFFF, 0, 0, 1'b1));
   endtask

   // one pixel wide, maximum height window: hits on the corners, misses just outside
   task automatic test_window_edges();
      wait_until_idle();
      write_register(CSR_X_LIMITS, 24'hFFF000);
      write_register(CSR_Y_LIMITS, 24'hFFF000);
      write_register(CSR_WIN_WIDTH, 24'd1);
      write_register(CSR_WIN_HEIGHT, 24'(MAX_WINDOW));
      send_pixel(near_window(0, 0, 24'h7F7F7F, 1'b0));
      send_pixel(near_window(0, MAX_WINDOW - 1, 24'h7F7F7F, 1'b0));
      send_pixel(near_window(1, 0, 24'h7F7F7F, 1'b0));
      send_pixel(near_window(0, MAX_WINDOW, 24'h7F7F7F, 1'b0));
      send_pixel(near_window(-1, 0, 24'h7F7F7F, 1'b0));
      send_pixel(near_window(0, -1, 24'h7F7F7F, 1'b1));
   endtask

   // inclusive bounds per channel, crossed bounds, all-high and all-low bounds
   task automatic test_channel_bounds();
      wait_until_idle();
      write_register(CSR_LOWER_BOUND, 24'h102030);
      write_register(CSR_UPPER_BOUND, 24'h405060);
      send_pixel(near_window(0, 0, 24'h102030, 1'b0));
      send_pixel(near_window(0, 1, 24'h405060, 1'b0));
      send_pixel(near_window(0, 2, 24'h10202F, 1'b0));
      send_pixel(near_window(0, 3, 24'h412030, 1'b0));
      send_pixel(near_window(0, 4, 24'h105130, 1'b1));
      wait_until_idle();
      write_register(CSR_LOWER_BOUND, 24'hFFFFFF);
      write_register(CSR_UPPER_BOUND, 24'hFFFFFF);
      send_pixel(near_window(0, 1, 24'hFFFFFF, 1'b0));
      send_pixel(near_window(0, 2, 24'hFFFFFE, 1'b1));
      // green lower above upper: never matches
      wait_until_idle();
      write_register(CSR_LOWER_BOUND, 24'h00FF00);
      write_register(CSR_UPPER_BOUND, 24'hFF00FF);
      send_pixel(near_window(0, 0, 24'h808080, 1'b1));
      wait_until_idle();
      write_register(CSR_LOWER_BOUND, 24'h000000);
      write_register(CSR_UPPER_BOUND, 24'h000000);
      send_pixel(near_window(0, 0, 24'h000000, 1'b1));
   endtask

   // crossed limits (right clamp wins, window goes negative), zero and all-ones limits
   task automatic test_limit_clamps();
      wait_until_idle();
      write_register(CSR_LOWER_BOUND, 24'h000000);
      write_register(CSR_UPPER_BOUND, 24'hFFFFFF);
      write_register(CSR_WIN_WIDTH, 24'd300);
      write_register(CSR_WIN_HEIGHT, 24'(MAX_WINDOW));
      write_register(CSR_X_LIMITS, {12'd100, 12'd3000});
      write_register(CSR_Y_LIMITS, 24'h000000);
      send_pixel(near_window(5, 5, 24'h123456, 1'b1));
      // window now entirely above row zero: nothing can match
      send_pixel(make_pixel(24'h123456, 50, 0, 1'b1));
      wait_until_idle();
      write_register(CSR_X_LIMITS, 24'hFFFFFF);
      write_register(CSR_Y_LIMITS, 24'hFFFFFF);
      write_register(CSR_WIN_WIDTH, 24'd1023);
      send_pixel(make_pixel(24'hABCDEF, 4095, 0, 1'b1));
   endtask

   // well-formed frames with random content, mixed with stray random pixels
   task automatic send_tracking_frames(input int n_items);
      int        sent;
      int        len;
      int        i;
      pixel_type px;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 15) begin
            px.blue = 8'($urandom);
            px.green = 8'($urandom);
            px.red = 8'($urandom);
            px.col = COORD_BITS'($urandom);
            px.row = COORD_BITS'($urandom);
            px.frame_end = 1'($urandom);
            send_pixel(px);
            sent++;
         end else begin
            len = $urandom_range(16, 1);
            for (i = 0; i < len; i++) begin
               send_pixel(frame_pixel(i == len - 1));
            end
            sent += len;
            // now and then the sender holds off until the result is back
            if ($urandom_range(19) == 0) begin
               hold_until_drained();
            end
         end
      end
   endtask

   // random configurations under each idling mix
   task automatic test_random_tracking();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         wait_until_idle();
         send_idle_pct = SEND_IDLE[phase % 4];
         recv_stall_pct = RECV_STALL[phase % 4];
         pick_random_setup();
         send_tracking_frames(PHASE_ITEMS);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_LOWER_BOUND;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.pixel_blue = '0;
      req_bus.pixel_green = '0;
      req_bus.pixel_red = '0;
      req_bus.pixel_x = '0;
      req_bus.pixel_y = '0;
      req_bus.frame_end = 1'b0;
      rsp_bus.ready = 1'b0;
      trk_win_x = 0;
      trk_win_y = 0;
      trk_cen_x = 0;
      trk_cen_y = 0;
      trk_first = 1'b1;
      trk_count = 0;
      trk_sum_x = 0;
      trk_sum_y = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_initial_window();
      test_window_edges();
      test_channel_bounds();
      test_limit_clamps();
      test_random_tracking();

      // let the last results come back, then allow for anything still in flight
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS color_window_centroid_tracker");
      end else begin
         $display("FAIL color_window_centroid_tracker");
      end
      $finish;
   end

endmodule
